@@ rtl/sdf_pkg.sv @@
package sdf_pkg;

  // Number format of coordinates, velocities and forces
  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int CfgW     = 32;
  // Unit direction is Q2.30
  localparam int DirW     = 32;
  localparam int DirSh    = 30;

  // Derived datapath widths
  localparam int DiffW = CoordW + 1;           // end_one - end_two
  localparam int SqW   = 2 * DiffW;            // one squared component
  localparam int SumW  = SqW + 2;              // sum of three squares
  localparam int RootW = (SumW + 1) / 2;       // integer square root
  localparam int RemW  = SumW + 1;             // root remainder
  localparam int QuotW = DirSh + 1;            // direction magnitude, up to 2^30
  localparam int DivW  = RootW + QuotW;        // divider remainder
  localparam int ProdW = CoordW + DirW;        // velocity times direction
  localparam int AccW  = ProdW + 2;            // dot product
  localparam int ProjW = AccW - DirSh;         // projected velocity
  localparam int StrW  = RootW + 1;            // stretch, signed
  localparam int KW    = CfgW + 1;             // coefficient as signed
  localparam int SkW   = StrW + KW;
  localparam int PcW   = ProjW + KW;
  localparam int TotW  = PcW - FracBits + 1;   // magnitude before saturation
  localparam int MdW   = CoordW + DirW;        // magnitude times direction
  localparam int FoW   = MdW - DirSh;          // force before saturation

  localparam logic [CfgW-1:0] StiffReset = CfgW'(65536);
  localparam logic [CfgW-1:0] DampReset  = '0;

  typedef enum logic [0:0] {
    CfgStiffness = 1'b0,
    CfgDamping   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] end_one_x;
    logic signed [CoordW-1:0] end_one_y;
    logic signed [CoordW-1:0] end_one_z;
    logic signed [CoordW-1:0] end_two_x;
    logic signed [CoordW-1:0] end_two_y;
    logic signed [CoordW-1:0] end_two_z;
    logic signed [CoordW-1:0] rel_vel_x;
    logic signed [CoordW-1:0] rel_vel_y;
    logic signed [CoordW-1:0] rel_vel_z;
    logic [CoordW-2:0]        rest_length;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] force_x;
    logic signed [CoordW-1:0] force_y;
    logic signed [CoordW-1:0] force_z;
    logic signed [DirW-1:0]   dir_x;
    logic signed [DirW-1:0]   dir_y;
    logic signed [DirW-1:0]   dir_z;
    logic                     degenerate;
  } out_t;

  // Per-spring data that rides along the root and divider pipelines
  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0][DiffW-1:0]   dmag;
    logic [2:0][CoordW-1:0]  vel;
    logic [CoordW-2:0]       rest;
    logic                    deg;
  } trk_t;

  // Saturate a wide signed value to the coordinate width
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [TotW-1:0] v);
    logic signed [TotW-1:0] hi;
    logic signed [TotW-1:0] lo;
    hi = TotW'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - TotW'(1);
    if (v > hi) begin
      sat_coord = {1'b0, {(CoordW-1){1'b1}}};
    end else if (v < lo) begin
      sat_coord = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      sat_coord = v[CoordW-1:0];
    end
  endfunction

endpackage

@@ rtl/spring_damper_force_core.sv @@
// Spring-damper force engine. One spring is accepted in every cycle (busy
// stays low). Each spring passes through 74 register stages: 3 front stages,
// 34 square root stages (one root bit each), 31 divider stages (one direction
// bit each) and 6 stages of multiply, sum and saturation. Its result is on
// res_o with done_o high for exactly one cycle, as it leaves the last stage,
// and is taken at the edge that ends that cycle. Most of the stages belong to
// the square root and divider pipelines. The receiver cannot stall, so every
// result must be taken in the cycle it is shown. Configuration writes are
// always ready and must only be issued while no spring is in flight.
module spring_damper_force_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  sdf_pkg::in_t                data_i,
  output logic                        done_o,
  output sdf_pkg::out_t               res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  sdf_pkg::cfg_reg_e           cfg_index_i,
  input  logic [sdf_pkg::CfgW-1:0]    cfg_data_i
);

  logic [sdf_pkg::CfgW-1:0] stiff_q;
  logic [sdf_pkg::CfgW-1:0] damp_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= sdf_pkg::StiffReset;
      damp_q  <= sdf_pkg::DampReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sdf_pkg::CfgStiffness: stiff_q <= cfg_data_i;
        sdf_pkg::CfgDamping:   damp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the front and back stages
  logic a_vld_q, b_vld_q, c_vld_q;
  logic p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q, p5_vld_q, p6_vld_q;
  logic sq_vld, dv_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
      p6_vld_q <= 1'b0;
    end else begin
      a_vld_q  <= start;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      p1_vld_q <= dv_vld;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
      p6_vld_q <= p5_vld_q;
    end
  end

  // Stage A: difference of the ends
  logic signed [2:0][sdf_pkg::DiffW-1:0] a_d_q;
  logic [2:0][sdf_pkg::CoordW-1:0]       a_v_q;
  logic [sdf_pkg::CoordW-2:0]            a_rest_q;

  always_ff @(posedge clk_i) begin
    a_d_q[0] <= sdf_pkg::DiffW'(data_i.end_one_x) - sdf_pkg::DiffW'(data_i.end_two_x);
    a_d_q[1] <= sdf_pkg::DiffW'(data_i.end_one_y) - sdf_pkg::DiffW'(data_i.end_two_y);
    a_d_q[2] <= sdf_pkg::DiffW'(data_i.end_one_z) - sdf_pkg::DiffW'(data_i.end_two_z);
    a_v_q[0] <= data_i.rel_vel_x;
    a_v_q[1] <= data_i.rel_vel_y;
    a_v_q[2] <= data_i.rel_vel_z;
    a_rest_q <= data_i.rest_length;
  end

  // Stage B: magnitudes and squares
  logic [2:0][sdf_pkg::DiffW-1:0] b_mag;
  logic [2:0][sdf_pkg::SqW-1:0]   b_sq_q;
  sdf_pkg::trk_t                  b_trk_q;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign b_mag[i] = a_d_q[i][sdf_pkg::DiffW-1] ? -a_d_q[i] : a_d_q[i];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      b_sq_q[i]          <= sdf_pkg::SqW'(b_mag[i]) * sdf_pkg::SqW'(b_mag[i]);
      b_trk_q.neg[i]     <= a_d_q[i][sdf_pkg::DiffW-1];
      b_trk_q.dmag[i]    <= b_mag[i];
      b_trk_q.vel[i]     <= a_v_q[i];
    end
    b_trk_q.rest <= a_rest_q;
    b_trk_q.deg  <= 1'b0;
  end

  // Stage C: squared length, coincident ends
  logic [sdf_pkg::SumW-1:0] c_sum;
  logic [sdf_pkg::SumW-1:0] c_sum_q;
  sdf_pkg::trk_t            c_trk;
  sdf_pkg::trk_t            c_trk_q;

  assign c_sum = sdf_pkg::SumW'(b_sq_q[0]) + sdf_pkg::SumW'(b_sq_q[1])
               + sdf_pkg::SumW'(b_sq_q[2]);

  // Mark coincident ends on the tracked data
  always_comb begin
    c_trk     = b_trk_q;
    c_trk.deg = (c_sum == '0);
  end

  always_ff @(posedge clk_i) begin
    c_sum_q <= c_sum;
    c_trk_q <= c_trk;
  end

  // Length and direction
  logic [sdf_pkg::RootW-1:0]       sq_root;
  sdf_pkg::trk_t                   sq_trk;
  logic [2:0][sdf_pkg::QuotW-1:0]  dv_quot;
  logic [sdf_pkg::RootW-1:0]       dv_root;
  sdf_pkg::trk_t                   dv_trk;

  sdf_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_vld_q),
    .in_sum_i    (c_sum_q),
    .in_trk_i    (c_trk_q),
    .out_valid_o (sq_vld),
    .out_root_o  (sq_root),
    .out_trk_o   (sq_trk)
  );

  sdf_dir_div u_dir_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_vld),
    .in_root_i   (sq_root),
    .in_trk_i    (sq_trk),
    .out_valid_o (dv_vld),
    .out_quot_o  (dv_quot),
    .out_root_o  (dv_root),
    .out_trk_o   (dv_trk)
  );

  // P1: signed direction, velocity products, stretch
  logic signed [2:0][sdf_pkg::DirW-1:0]  p1_dir;
  logic signed [2:0][sdf_pkg::DirW-1:0]  p1_dir_q;
  logic signed [2:0][sdf_pkg::ProdW-1:0] p1_prod_q;
  logic signed [sdf_pkg::StrW-1:0]       p1_str_q;
  logic                                  p1_deg_q;

  for (genvar i = 0; i < 3; i++) begin : g_dir
    assign p1_dir[i] = dv_trk.neg[i] ? -sdf_pkg::DirW'(dv_quot[i])
                                     : sdf_pkg::DirW'(dv_quot[i]);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p1_prod_q[i] <= sdf_pkg::ProdW'($signed(dv_trk.vel[i]))
                    * sdf_pkg::ProdW'($signed(p1_dir[i]));
    end
    p1_dir_q <= p1_dir;
    p1_str_q <= $signed(sdf_pkg::StrW'(dv_root)) - $signed(sdf_pkg::StrW'(dv_trk.rest));
    p1_deg_q <= dv_trk.deg;
  end

  // P2: projected velocity, spring term
  logic signed [sdf_pkg::AccW-1:0]      p2_acc;
  logic signed [sdf_pkg::ProjW-1:0]     p2_proj_q;
  logic signed [sdf_pkg::SkW-1:0]       p2_sk_q;
  logic signed [2:0][sdf_pkg::DirW-1:0] p2_dir_q;
  logic                                 p2_deg_q;

  assign p2_acc = sdf_pkg::AccW'($signed(p1_prod_q[0])) + sdf_pkg::AccW'($signed(p1_prod_q[1]))
                + sdf_pkg::AccW'($signed(p1_prod_q[2]));

  always_ff @(posedge clk_i) begin
    p2_proj_q <= sdf_pkg::ProjW'(p2_acc >>> sdf_pkg::DirSh);
    p2_sk_q   <= sdf_pkg::SkW'(p1_str_q) * $signed(sdf_pkg::SkW'(stiff_q));
    p2_dir_q  <= p1_dir_q;
    p2_deg_q  <= p1_deg_q;
  end

  // P3: damping term
  logic signed [sdf_pkg::PcW-1:0]       p3_pc_q;
  logic signed [sdf_pkg::SkW-1:0]       p3_sk_q;
  logic signed [2:0][sdf_pkg::DirW-1:0] p3_dir_q;
  logic                                 p3_deg_q;

  always_ff @(posedge clk_i) begin
    p3_pc_q  <= sdf_pkg::PcW'(p2_proj_q) * $signed(sdf_pkg::PcW'(damp_q));
    p3_sk_q  <= p2_sk_q;
    p3_dir_q <= p2_dir_q;
    p3_deg_q <= p2_deg_q;
  end

  // P4: magnitude, saturated
  logic signed [sdf_pkg::TotW-1:0]      p4_tot;
  logic signed [sdf_pkg::CoordW-1:0]    p4_mag_q;
  logic signed [2:0][sdf_pkg::DirW-1:0] p4_dir_q;
  logic                                 p4_deg_q;

  assign p4_tot = sdf_pkg::TotW'(p3_sk_q >>> sdf_pkg::FracBits)
                + sdf_pkg::TotW'(p3_pc_q >>> sdf_pkg::FracBits);

  always_ff @(posedge clk_i) begin
    p4_mag_q <= sdf_pkg::sat_coord(p4_tot);
    p4_dir_q <= p3_dir_q;
    p4_deg_q <= p3_deg_q;
  end

  // P5: scale direction by magnitude
  logic signed [2:0][sdf_pkg::MdW-1:0]  p5_md_q;
  logic signed [2:0][sdf_pkg::DirW-1:0] p5_dir_q;
  logic                                 p5_deg_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p5_md_q[i] <= sdf_pkg::MdW'(p4_mag_q) * sdf_pkg::MdW'($signed(p4_dir_q[i]));
    end
    p5_dir_q <= p4_dir_q;
    p5_deg_q <= p4_deg_q;
  end

  // P6: saturate force, zero force and direction for coincident ends
  logic signed [2:0][sdf_pkg::FoW-1:0]    p6_fo;
  logic signed [2:0][sdf_pkg::CoordW-1:0] p6_force;
  sdf_pkg::out_t                          res_q;

  for (genvar i = 0; i < 3; i++) begin : g_force
    assign p6_fo[i]    = sdf_pkg::FoW'($signed(p5_md_q[i]) >>> sdf_pkg::DirSh);
    assign p6_force[i] = sdf_pkg::sat_coord(sdf_pkg::TotW'($signed(p6_fo[i])));
  end

  always_ff @(posedge clk_i) begin
    res_q.force_x    <= p5_deg_q ? '0 : p6_force[0];
    res_q.force_y    <= p5_deg_q ? '0 : p6_force[1];
    res_q.force_z    <= p5_deg_q ? '0 : p6_force[2];
    res_q.dir_x      <= p5_deg_q ? '0 : p5_dir_q[0];
    res_q.dir_y      <= p5_deg_q ? '0 : p5_dir_q[1];
    res_q.dir_z      <= p5_deg_q ? '0 : p5_dir_q[2];
    res_q.degenerate <= p5_deg_q;
  end

  assign done_o = p6_vld_q;
  assign res_o  = res_q;

endmodule

@@ rtl/sdf_isqrt.sv @@
// Pipelined integer square root, one result bit per stage
module sdf_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sdf_pkg::SumW-1:0]    in_sum_i,
  input  sdf_pkg::trk_t               in_trk_i,
  output logic                        out_valid_o,
  output logic [sdf_pkg::RootW-1:0]   out_root_o,
  output sdf_pkg::trk_t               out_trk_o
);

  localparam int N = sdf_pkg::RootW;

  logic                         vld  [N+1];
  logic [sdf_pkg::RemW-1:0]     rem  [N+1];
  logic [sdf_pkg::RootW-1:0]    root [N+1];
  sdf_pkg::trk_t                trk  [N+1];

  assign vld[0]  = in_valid_i;
  assign rem[0]  = sdf_pkg::RemW'(in_sum_i);
  assign root[0] = '0;
  assign trk[0]  = in_trk_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [sdf_pkg::RemW-1:0]  trial;
    logic                      take;
    logic                      vld_q;
    logic [sdf_pkg::RemW-1:0]  rem_q;
    logic [sdf_pkg::RootW-1:0] root_q;
    sdf_pkg::trk_t             trk_q;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign trial = (sdf_pkg::RemW'(root[k]) << (B + 1)) | (sdf_pkg::RemW'(1) << (2 * B));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[k];
      end
    end

    // Try this bit, keep it when the remainder allows
    always_ff @(posedge clk_i) begin
      rem_q  <= take ? rem[k] - trial : rem[k];
      root_q <= take ? root[k] | (sdf_pkg::RootW'(1) << B) : root[k];
      trk_q  <= trk[k];
    end

    assign vld[k+1]  = vld_q;
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign trk[k+1]  = trk_q;
  end

  assign out_valid_o = vld[N];
  assign out_root_o  = root[N];
  assign out_trk_o   = trk[N];

endmodule

@@ rtl/sdf_dir_div.sv @@
// Pipelined restoring divider, three lanes: |d_i| * 2^30 / length
module sdf_dir_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  logic [sdf_pkg::RootW-1:0]               in_root_i,
  input  sdf_pkg::trk_t                           in_trk_i,
  output logic                                    out_valid_o,
  output logic [2:0][sdf_pkg::QuotW-1:0]          out_quot_o,
  output logic [sdf_pkg::RootW-1:0]               out_root_o,
  output sdf_pkg::trk_t                           out_trk_o
);

  localparam int N = sdf_pkg::QuotW;

  logic                                  vld  [N+1];
  logic [2:0][sdf_pkg::DivW-1:0]         rem  [N+1];
  logic [2:0][sdf_pkg::QuotW-1:0]        quot [N+1];
  logic [sdf_pkg::RootW-1:0]             root [N+1];
  sdf_pkg::trk_t                         trk  [N+1];

  assign vld[0]  = in_valid_i;
  assign root[0] = in_root_i;
  assign trk[0]  = in_trk_i;
  assign quot[0] = '0;
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = sdf_pkg::DivW'(in_trk_i.dmag[l]) << sdf_pkg::DirSh;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int J = N - 1 - k;
    logic [sdf_pkg::DivW-1:0]        den;
    logic                            vld_q;
    logic [2:0][sdf_pkg::DivW-1:0]   rem_q;
    logic [2:0][sdf_pkg::QuotW-1:0]  quot_q;
    logic [sdf_pkg::RootW-1:0]       root_q;
    sdf_pkg::trk_t                   trk_q;

    assign den = sdf_pkg::DivW'(root[k]) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[k];
      end
    end

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 3; l++) begin
        if (rem[k][l] >= den) begin
          rem_q[l]  <= rem[k][l] - den;
          quot_q[l] <= quot[k][l] | (sdf_pkg::QuotW'(1) << J);
        end else begin
          rem_q[l]  <= rem[k][l];
          quot_q[l] <= quot[k][l];
        end
      end
      root_q <= root[k];
      trk_q  <= trk[k];
    end

    assign vld[k+1]  = vld_q;
    assign rem[k+1]  = rem_q;
    assign quot[k+1] = quot_q;
    assign root[k+1] = root_q;
    assign trk[k+1]  = trk_q;
  end

  assign out_valid_o = vld[N];
  assign out_quot_o  = quot[N];
  assign out_root_o  = root[N];
  assign out_trk_o   = trk[N];

endmodule

@@ verif/tb_spring_damper_force_core.sv @@
`timescale 1ns / 100ps

module tb_spring_damper_force_core;

  localparam int ResetCycles = 12;
  localparam int DrainCycles = 100;
  localparam logic signed [127:0] ForceMax = 128'sd2147483647;
  localparam logic signed [127:0] ForceMin = -128'sd2147483648;
  localparam logic [127:0] DirOne = 128'd1 << sdf_pkg::DirSh;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  sdf_pkg::in_t     data_i = '0;
  logic        done_o;
  sdf_pkg::out_t    res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  sdf_pkg::cfg_reg_e cfg_index_i = sdf_pkg::CfgStiffness;
  logic [sdf_pkg::CfgW-1:0] cfg_data_i = '0;

  // Shadow copy of the coefficient registers
  logic [sdf_pkg::CfgW-1:0] stiffness = sdf_pkg::StiffReset;
  logic [sdf_pkg::CfgW-1:0] damping   = sdf_pkg::DampReset;

  sdf_pkg::out_t force_queue[$];
  int   n_errors = 0;
  int   n_springs = 0;
  int   n_checked = 0;
  int   n_degenerate = 0;
  int   n_cfg_writes = 0;
  bit   gaps_on = 1'b1;

  spring_damper_force_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .data_i      (data_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Clamp a wide signed value to the force range
  function automatic logic signed [31:0] clamp_force(input logic signed [127:0] v);
    if (v > ForceMax) begin
      return 32'sh7FFFFFFF;
    end else if (v < ForceMin) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Floor square root, one bit at a time
  function automatic logic [63:0] spring_length(input logic [127:0] sq);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= sq) r = c;
    end
    return r;
  endfunction

  // Force on end two and unit direction for one spring
  function automatic sdf_pkg::out_t spring_force(input sdf_pkg::in_t s);
    logic signed [127:0] d [3];
    logic signed [127:0] v [3];
    logic signed [127:0] dr [3];
    logic [127:0] sq;
    logic [127:0] mg;
    logic [127:0] q;
    logic [63:0]  len;
    logic signed [127:0] acc;
    logic signed [127:0] proj;
    logic signed [127:0] stretch;
    logic signed [127:0] total;
    logic signed [127:0] mag;
    sdf_pkg::out_t o;
    d[0] = 128'(s.end_one_x) - 128'(s.end_two_x);
    d[1] = 128'(s.end_one_y) - 128'(s.end_two_y);
    d[2] = 128'(s.end_one_z) - 128'(s.end_two_z);
    v[0] = 128'(s.rel_vel_x);
    v[1] = 128'(s.rel_vel_y);
    v[2] = 128'(s.rel_vel_z);
    o = '0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mg = (d[i] < 0) ? -d[i] : d[i];
      sq = sq + mg * mg;
    end
    if (sq == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    len = spring_length(sq);
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mg = (d[i] < 0) ? -d[i] : d[i];
      q = (mg << sdf_pkg::DirSh) / {64'd0, len};
      if (q > DirOne) q = DirOne;
      dr[i] = (d[i] < 0) ? -$signed(q) : $signed(q);
      acc = acc + v[i] * dr[i];
    end
    proj = acc >>> sdf_pkg::DirSh;
    stretch = $signed({64'd0, len}) - $signed({97'd0, s.rest_length});
    total = ((stretch * $signed({96'd0, stiffness})) >>> sdf_pkg::FracBits)
          + ((proj * $signed({96'd0, damping})) >>> sdf_pkg::FracBits);
    mag = 128'(clamp_force(total));
    o.force_x = clamp_force((mag * dr[0]) >>> sdf_pkg::DirSh);
    o.force_y = clamp_force((mag * dr[1]) >>> sdf_pkg::DirSh);
    o.force_z = clamp_force((mag * dr[2]) >>> sdf_pkg::DirSh);
    o.dir_x = dr[0][31:0];
    o.dir_y = dr[1][31:0];
    o.dir_z = dr[2][31:0];
    return o;
  endfunction

  // Drive one spring and hold it until the core takes the beat
  task automatic send_spring(input sdf_pkg::in_t s);
    @(negedge clk_i);
    start  <= 1'b1;
    data_i <= s;
    do @(posedge clk_i); while (busy);
    force_queue.push_back(spring_force(s));
    n_springs++;
  endtask

  // Drop start for a random gap now and then
  task automatic maybe_idle();
    int n;
    if (gaps_on && $urandom_range(0, 99) < 19) begin
      n = $urandom_range(1, 6);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Let the pipeline drain, then write one coefficient
  task automatic write_coeff(input sdf_pkg::cfg_reg_e idx,
                             input logic [sdf_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    start <= 1'b0;
    wait (force_queue.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == sdf_pkg::CfgStiffness) stiffness = val;
    else damping = val;
    n_cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(input bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 2097152) - 1048576;
  endfunction

  function automatic sdf_pkg::in_t rand_spring(input bit wide);
    sdf_pkg::in_t s;
    s.end_one_x = rand_coord(wide);
    s.end_one_y = rand_coord(wide);
    s.end_one_z = rand_coord(wide);
    s.end_two_x = rand_coord(wide);
    s.end_two_y = rand_coord(wide);
    s.end_two_z = rand_coord(wide);
    s.rel_vel_x = rand_coord(wide);
    s.rel_vel_y = rand_coord(wide);
    s.rel_vel_z = rand_coord(wide);
    s.rest_length = wide ? 31'($urandom) : 31'($urandom_range(0, 2097152));
    return s;
  endfunction

  function automatic sdf_pkg::in_t make_spring(input logic signed [31:0] ax, ay, az, bx, by, bz,
                                               input logic signed [31:0] vx, vy, vz,
                                               input logic [30:0] rest);
    sdf_pkg::in_t s;
    s.end_one_x = ax; s.end_one_y = ay; s.end_one_z = az;
    s.end_two_x = bx; s.end_two_y = by; s.end_two_z = bz;
    s.rel_vel_x = vx; s.rel_vel_y = vy; s.rel_vel_z = vz;
    s.rest_length = rest;
    return s;
  endfunction

  // Coincident ends, axis springs and extreme coordinates at the current coefficients
  task automatic test_directed();
    send_spring(make_spring(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h0));
    send_spring(make_spring(32'sh7FFFFFFF, 5, -7, 32'sh7FFFFFFF, 5, -7,
                            32'sh7FFFFFFF, 0, 32'sh80000000, 31'h7FFFFFFF));
    send_spring(make_spring(32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0, 31'h0));
    send_spring(make_spring(0, -32'sh20000, 0, 0, 0, 0, 0, 32'sh10000, 0, 31'h10000));
    send_spring(make_spring(0, 0, 32'sh30000, 0, 0, 0, 0, 0, -32'sh10000, 31'h50000));
    send_spring(make_spring(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                            32'sh80000000, 32'sh80000000, 32'sh80000000,
                            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h0));
    send_spring(make_spring(32'sh80000000, 32'sh80000000, 32'sh80000000,
                            32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                            32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF));
    send_spring(make_spring(1, 0, 0, 0, 0, 0, -1, -1, -1, 31'h0));
    send_spring(make_spring(1, 1, 1, 0, 0, 0, 1, 1, 1, 31'h7FFFFFFF));
    send_spring(make_spring(32'shFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 31'h1));
  endtask

  // Run random springs: mostly moderate geometry, some full-range noise, some coincident ends
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) gaps_on = 1'b0;
      if (i == count / 2) gaps_on = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        send_spring(make_spring(7, -3, 9, 7, -3, 9, rand_coord(1), rand_coord(1),
                                rand_coord(1), 31'($urandom)));
      end else begin
        send_spring(rand_spring($urandom_range(0, 3) == 0));
      end
      maybe_idle();
    end
  endtask

  // Exercise the coefficient extremes, one fixed setting and random settings
  task automatic test_coefficients();
    write_coeff(sdf_pkg::CfgStiffness, '0);
    write_coeff(sdf_pkg::CfgDamping, '0);
    test_directed();
    test_random(40);
    write_coeff(sdf_pkg::CfgStiffness, '1);
    write_coeff(sdf_pkg::CfgDamping, '1);
    test_directed();
    test_random(60);
    write_coeff(sdf_pkg::CfgStiffness, 32'h0002_8000);
    write_coeff(sdf_pkg::CfgDamping, 32'h0000_4000);
    test_random(100);
    write_coeff(sdf_pkg::CfgStiffness, $urandom);
    write_coeff(sdf_pkg::CfgDamping, $urandom);
    test_random(100);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      n_errors++;
    end
  endtask

  // Compare each result beat with the oldest pending force
  always @(posedge clk_i) begin
    sdf_pkg::out_t want;
    if (rst_ni && done_o) begin
      if (force_queue.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h", $realtime, res_o);
        n_errors++;
      end else begin
        want = force_queue.pop_front();
        check_field("force_x", want.force_x, res_o.force_x);
        check_field("force_y", want.force_y, res_o.force_y);
        check_field("force_z", want.force_z, res_o.force_z);
        check_field("dir_x", want.dir_x, res_o.dir_x);
        check_field("dir_y", want.dir_y, res_o.dir_y);
        check_field("dir_z", want.dir_z, res_o.dir_z);
        check_field("degenerate", 32'(want.degenerate), 32'(res_o.degenerate));
        if (want.degenerate) n_degenerate++;
        n_checked++;
      end
    end
  end

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(140);
    test_coefficients();
    @(negedge clk_i);
    start <= 1'b0;
    wait (force_queue.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    $display("Checked %0d of %0d springs (%0d coincident) over %0d coefficient writes.",
             n_checked, n_springs, n_degenerate, n_cfg_writes);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results pending", force_queue.size());
    $display("FAILURE");
    $finish;
  end

endmodule
